// ===== hw/rtl/l1net_pkg.sv =====
// Shared types, widths and codes for the L1 nearest-entry table.
`timescale 1ns / 1ps

package l1net_pkg;

   localparam int unsigned TABLE_DEPTH = 64;
   localparam int unsigned KEY_BITS    = 24;

   localparam int unsigned KEY_IN_BITS  = 24;
   localparam int unsigned PAYLOAD_BITS = 8;
   localparam int unsigned DIST_OUT_BITS = 25;
   localparam int unsigned FCOUNT_BITS  = 9;

   localparam int unsigned DIST_BITS  = KEY_BITS + 1;
   localparam int unsigned CNT_BITS   = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned ADDR_BITS  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned ENTRY_BITS = 2 * KEY_BITS + PAYLOAD_BITS;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_INDEX_ERROR = 2'd1;
   localparam logic [1:0] STATUS_TABLE_FULL  = 2'd2;

   typedef struct packed {
      logic                     op;
      logic [KEY_IN_BITS-1:0]   key_first;
      logic [KEY_IN_BITS-1:0]   key_second;
      logic [PAYLOAD_BITS-1:0]  payload_index;
   } req_type;

   typedef struct packed {
      logic [PAYLOAD_BITS-1:0]  chosen_index;
      logic [DIST_OUT_BITS-1:0] best_distance;
      logic                     found;
      logic [1:0]               status;
   } rsp_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]     key_first;
      logic [KEY_BITS-1:0]     key_second;
      logic [PAYLOAD_BITS-1:0] payload;
   } entry_type;

endpackage

// ===== hw/rtl/l1net_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module l1net_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                             wr_data,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/l1net_dist.sv =====
// Manhattan distance unit shared by every step of a lookup scan.
`timescale 1ns / 1ps

module l1net_dist (
   input  logic [l1net_pkg::KEY_BITS-1:0]  entry_first,
   input  logic [l1net_pkg::KEY_BITS-1:0]  entry_second,
   input  logic [l1net_pkg::KEY_BITS-1:0]  query_first,
   input  logic [l1net_pkg::KEY_BITS-1:0]  query_second,
   output logic [l1net_pkg::DIST_BITS-1:0] distance
);

   import l1net_pkg::*;

   logic [KEY_BITS-1:0] diff_first;
   logic [KEY_BITS-1:0] diff_second;

   always_comb begin
      diff_first  = (entry_first >= query_first) ? (entry_first - query_first)
                                                 : (query_first - entry_first);
      diff_second = (entry_second >= query_second) ? (entry_second - query_second)
                                                   : (query_second - entry_second);
      distance    = {1'b0, diff_first} + {1'b0, diff_second};
   end

endmodule

// ===== hw/rtl/l1_nearest_entry_table.sv =====
// Top level of the L1 nearest-entry table with its scan sequencer.
`timescale 1ns / 1ps

// The table stores up to 64 entries, each two coordinates and a payload index,
// in a single-port RAM. An insert that finds room is written when it is taken,
// and its response is valid in the next cycle. A lookup walks the stored
// entries through the RAM read port and one shared distance unit, one entry
// per cycle. Each entry passes through the RAM read register and the distance
// register before it is compared with the best so far, and the response is
// registered once the scan has drained. After the response is taken the block
// returns to idle before it takes the next request. The block takes one
// request at a time: req_stall is high from acceptance until the response has
// been taken. The function count register should be written only while no
// request is in flight.

module l1_nearest_entry_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  l1net_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output l1net_pkg::rsp_type                  rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [l1net_pkg::FCOUNT_BITS-1:0]   csr_wdata
);

   import l1net_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [FCOUNT_BITS-1:0]  fcount_ff, fcount_in;
   logic [CNT_BITS-1:0]     rd_cnt_ff, rd_cnt_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic                    dist_vld_ff, dist_vld_in;
   logic                    best_vld_ff, best_vld_in;
   logic [DIST_BITS-1:0]    dist_ff, dist_in;
   logic [PAYLOAD_BITS-1:0] dist_pay_ff, dist_pay_in;
   logic [DIST_BITS-1:0]    best_ff, best_in;
   logic [PAYLOAD_BITS-1:0] best_pay_ff, best_pay_in;
   logic [KEY_BITS-1:0]     q_first_ff, q_first_in;
   logic [KEY_BITS-1:0]     q_second_ff, q_second_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    req_accept;
   logic                    issue;
   logic                    scan_done;
   logic                    ram_we;
   logic [ADDR_BITS-1:0]    ram_addr;
   entry_type               ram_wdata;
   entry_type               ram_rdata;
   logic [DIST_BITS-1:0]    unit_dist;
   logic [KEY_BITS+KEY_IN_BITS-1:0]  key_first_wide;
   logic [KEY_BITS+KEY_IN_BITS-1:0]  key_second_wide;
   logic [DIST_BITS+DIST_OUT_BITS-1:0] best_wide;

   l1net_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   l1net_dist u_dist (
      .entry_first  (ram_rdata.key_first),
      .entry_second (ram_rdata.key_second),
      .query_first  (q_first_ff),
      .query_second (q_second_ff),
      .distance     (unit_dist)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = (state_ff == ST_RESP);
   assign rsp_data   = rsp_ff;
   assign csr_ready  = 1'b1;
   assign req_accept = req_valid && !req_stall;

   assign key_first_wide  = {{KEY_BITS{1'b0}}, req_data.key_first};
   assign key_second_wide = {{KEY_BITS{1'b0}}, req_data.key_second};
   assign best_wide       = {{DIST_OUT_BITS{1'b0}}, best_ff};

   assign issue     = (state_ff == ST_SCAN) && (rd_cnt_ff < count_ff);
   assign scan_done = (state_ff == ST_SCAN) && !issue && !rd_vld_ff && !dist_vld_ff;

   always_comb begin
      ram_we               = req_accept && (req_data.op == OP_INSERT)
                             && (count_ff < CNT_BITS'(TABLE_DEPTH));
      ram_addr             = (state_ff == ST_SCAN) ? rd_cnt_ff[ADDR_BITS-1:0]
                                                   : count_ff[ADDR_BITS-1:0];
      ram_wdata.key_first  = key_first_wide[KEY_BITS-1:0];
      ram_wdata.key_second = key_second_wide[KEY_BITS-1:0];
      ram_wdata.payload    = req_data.payload_index;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      fcount_in   = fcount_ff;
      rd_cnt_in   = rd_cnt_ff;
      rd_vld_in   = issue;
      dist_vld_in = rd_vld_ff;
      dist_in     = unit_dist;
      dist_pay_in = ram_rdata.payload;
      best_vld_in = best_vld_ff;
      best_in     = best_ff;
      best_pay_in = best_pay_ff;
      q_first_in  = q_first_ff;
      q_second_in = q_second_ff;
      rsp_in      = rsp_ff;

      if (csr_valid && csr_ready) begin
         fcount_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               q_first_in  = key_first_wide[KEY_BITS-1:0];
               q_second_in = key_second_wide[KEY_BITS-1:0];
               rd_cnt_in   = '0;
               best_vld_in = 1'b0;
               if (req_data.op == OP_INSERT) begin
                  rsp_in.chosen_index  = '0;
                  rsp_in.best_distance = '0;
                  rsp_in.found         = 1'b0;
                  if (ram_we) begin
                     count_in      = count_ff + 1'b1;
                     rsp_in.status = STATUS_OK;
                  end else begin
                     rsp_in.status = STATUS_TABLE_FULL;
                  end
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
            if (dist_vld_ff && (!best_vld_ff || (dist_ff < best_ff))) begin
               best_vld_in = 1'b1;
               best_in     = dist_ff;
               best_pay_in = dist_pay_ff;
            end
            if (scan_done) begin
               if (best_vld_ff) begin
                  rsp_in.chosen_index  = best_pay_ff;
                  rsp_in.best_distance = best_wide[DIST_OUT_BITS-1:0];
                  rsp_in.found         = 1'b1;
                  rsp_in.status        = ({1'b0, best_pay_ff} >= fcount_ff)
                                         ? STATUS_INDEX_ERROR : STATUS_OK;
               end else begin
                  rsp_in.chosen_index  = '0;
                  rsp_in.best_distance = '0;
                  rsp_in.found         = 1'b0;
                  rsp_in.status        = (fcount_ff == '0) ? STATUS_INDEX_ERROR
                                                           : STATUS_OK;
               end
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         fcount_ff   <= '0;
         rd_cnt_ff   <= '0;
         rd_vld_ff   <= 1'b0;
         dist_vld_ff <= 1'b0;
         best_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         fcount_ff   <= fcount_in;
         rd_cnt_ff   <= rd_cnt_in;
         rd_vld_ff   <= rd_vld_in;
         dist_vld_ff <= dist_vld_in;
         best_vld_ff <= best_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff     <= dist_in;
      dist_pay_ff <= dist_pay_in;
      best_ff     <= best_in;
      best_pay_ff <= best_pay_in;
      q_first_ff  <= q_first_in;
      q_second_ff <= q_second_in;
      rsp_ff      <= rsp_in;
   end

endmodule

// ===== tb/sv/l1_nearest_entry_table_tb.sv =====
// Self-checking testbench for the L1 nearest-entry table with directed and random requests.
`timescale 1ns / 1ps

module l1_nearest_entry_table_tb;
   import l1net_pkg::*;

   localparam int KEY_TOP         = (1 << KEY_IN_BITS) - 1;
   localparam int CLUSTER_BASE    = 24'h400000;
   localparam int NO_WRITE        = -1;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 205;
   localparam int HOLD_CYCLES     = 300;
   localparam int DRAIN_CYCLES    = 80;
   localparam int STALL_LIMIT     = 4000;

   typedef struct {
      int      fc;
      req_type item;
      logic    typed;
      rsp_type want;
   } dir_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [FCOUNT_BITS-1:0] csr_wdata = '0;

   logic [KEY_BITS-1:0]     tbl_first   [TABLE_DEPTH];
   logic [KEY_BITS-1:0]     tbl_second  [TABLE_DEPTH];
   logic [PAYLOAD_BITS-1:0] tbl_payload [TABLE_DEPTH];
   int                      tbl_count = 0;
   logic [FCOUNT_BITS-1:0]  fcount_shadow = '0;

   rsp_type     rsp_backlog [$];
   rsp_type     head_rsp;
   dir_row_type dir_rows [$];
   int          fc_plan [PHASES];
   int          mismatch_count = 0;
   int          idle_cycles = 0;
   int          send_idle_pct = 0;
   int          rcv_stall_pct = 0;
   int          hold_ask = 0;
   int          hold_seen = 0;
   int          hold_left = 0;

   l1_nearest_entry_table i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic rsp_type nearest_response(input req_type r);
      rsp_type             o;
      logic [KEY_BITS-1:0] q0;
      logic [KEY_BITS-1:0] q1;
      logic [40:0]         best;
      logic [40:0]         d;
      o  = '0;
      q0 = r.key_first[KEY_BITS-1:0];
      q1 = r.key_second[KEY_BITS-1:0];
      if (r.op == OP_INSERT) begin
         if (tbl_count >= TABLE_DEPTH) begin
            o.status = STATUS_TABLE_FULL;
         end else begin
            tbl_first[tbl_count]   = q0;
            tbl_second[tbl_count]  = q1;
            tbl_payload[tbl_count] = r.payload_index;
            tbl_count++;
         end
      end else begin
         best = 41'd1 << 40;
         for (int i = 0; i < tbl_count; i++) begin
            d = 41'(tbl_first[i] >= q0 ? tbl_first[i] - q0 : q0 - tbl_first[i])
              + 41'(tbl_second[i] >= q1 ? tbl_second[i] - q1 : q1 - tbl_second[i]);
            if (d < best) begin
               best = d;
               o.chosen_index = tbl_payload[i];
            end
         end
         if (tbl_count > 0) begin
            o.found = 1'b1;
            o.best_distance = best[DIST_OUT_BITS-1:0];
         end
         if ({1'b0, o.chosen_index} >= fcount_shadow) begin
            o.status = STATUS_INDEX_ERROR;
         end
      end
      return o;
   endfunction

   function automatic req_type pick_req();
      req_type r;
      int      sel;
      int      j;
      r.op = ($urandom_range(0, 99) < 20) ? OP_INSERT : OP_LOOKUP;
      r.payload_index = PAYLOAD_BITS'($urandom_range(0, 255));
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
         r.key_first  = KEY_IN_BITS'($urandom_range(0, KEY_TOP));
         r.key_second = KEY_IN_BITS'($urandom_range(0, KEY_TOP));
      end else if (sel == 4) begin
         r.key_first  = $urandom_range(0, 1) ? KEY_IN_BITS'(KEY_TOP) : '0;
         r.key_second = $urandom_range(0, 1) ? KEY_IN_BITS'(KEY_TOP) : '0;
      end else if (sel < 8 && tbl_count > 0) begin
         j = $urandom_range(0, tbl_count - 1);
         r.key_first  = tbl_first[j] ^ KEY_IN_BITS'($urandom_range(0, 7));
         r.key_second = tbl_second[j] ^ KEY_IN_BITS'($urandom_range(0, 7));
      end else begin
         r.key_first  = KEY_IN_BITS'(CLUSTER_BASE + $urandom_range(0, 31));
         r.key_second = KEY_IN_BITS'(CLUSTER_BASE + $urandom_range(0, 31));
      end
      return r;
   endfunction

   function automatic void add_row(input int fc, input logic op, input int k0, input int k1,
                                   input int pay, input logic typed, input int w_idx,
                                   input int w_dist, input logic w_found,
                                   input logic [1:0] w_status);
      dir_row_type row;
      row.fc                     = fc;
      row.item.op                = op;
      row.item.key_first         = KEY_IN_BITS'(k0);
      row.item.key_second        = KEY_IN_BITS'(k1);
      row.item.payload_index     = PAYLOAD_BITS'(pay);
      row.typed                  = typed;
      row.want.chosen_index      = PAYLOAD_BITS'(w_idx);
      row.want.best_distance     = DIST_OUT_BITS'(w_dist);
      row.want.found             = w_found;
      row.want.status            = w_status;
      dir_rows = {dir_rows, row};
   endfunction

   task automatic offer(input req_type r, input rsp_type want);
      int   gap;
      logic taken;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      rsp_backlog = {rsp_backlog, want};
   endtask

   task automatic write_fcount(input int v);
      logic taken;
      req_valid <= 1'b0;
      while (rsp_backlog.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= FCOUNT_BITS'(v);
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
      fcount_shadow = FCOUNT_BITS'(v);
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_ask != hold_seen) begin
         hold_seen = hold_ask;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_backlog.size() == 0) begin
            $display("%0t: response with none outstanding, expected none, got %h",
                     $time, rsp_data);
            mismatch_count++;
         end else begin
            head_rsp = rsp_backlog.pop_front();
            if (rsp_data.chosen_index !== head_rsp.chosen_index) begin
               $display("%0t: chosen_index expected %0h got %0h",
                        $time, head_rsp.chosen_index, rsp_data.chosen_index);
               mismatch_count++;
            end
            if (rsp_data.best_distance !== head_rsp.best_distance) begin
               $display("%0t: best_distance expected %0h got %0h",
                        $time, head_rsp.best_distance, rsp_data.best_distance);
               mismatch_count++;
            end
            if (rsp_data.found !== head_rsp.found) begin
               $display("%0t: found expected %0b got %0b",
                        $time, head_rsp.found, rsp_data.found);
               mismatch_count++;
            end
            if (rsp_data.status !== head_rsp.status) begin
               $display("%0t: status expected %0d got %0d",
                        $time, head_rsp.status, rsp_data.status);
               mismatch_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("l1_nearest_entry_table_tb: FAIL");
         $finish;
      end
   end

   initial begin
      req_type r;
      rsp_type want;

      // fc      op         key_first  key_second pay   typed chosen dist       found status
      add_row(NO_WRITE, OP_LOOKUP, 0,         0,         0,    1, 0,    0,         0, STATUS_INDEX_ERROR);
      add_row(1,        OP_LOOKUP, 'hFFFFFF,  'hFFFFFF,  0,    1, 0,    0,         0, STATUS_OK);
      add_row(NO_WRITE, OP_INSERT, 'hFFFFFF,  'hFFFFFF,  'hFF, 1, 0,    0,         0, STATUS_OK);
      add_row(NO_WRITE, OP_LOOKUP, 0,         0,         0,    1, 'hFF, 'h1FFFFFE, 1, STATUS_INDEX_ERROR);
      add_row(256,      OP_LOOKUP, 0,         0,         'hFF, 1, 'hFF, 'h1FFFFFE, 1, STATUS_OK);
      add_row(NO_WRITE, OP_INSERT, 0,         0,         0,    1, 0,    0,         0, STATUS_OK);
      add_row(NO_WRITE, OP_LOOKUP, 0,         'hFFFFFF,  0,    1, 'hFF, 'hFFFFFF,  1, STATUS_OK);
      add_row(NO_WRITE, OP_LOOKUP, 'hFFFFFF,  0,         0,    1, 'hFF, 'hFFFFFF,  1, STATUS_OK);
      add_row(NO_WRITE, OP_LOOKUP, 1,         1,         0,    0, 0,    0,         0, STATUS_OK);
      add_row(NO_WRITE, OP_INSERT, 0,         0,         'h5A, 1, 0,    0,         0, STATUS_OK);
      add_row(NO_WRITE, OP_LOOKUP, 0,         0,         0,    0, 0,    0,         0, STATUS_OK);
      add_row(NO_WRITE, OP_INSERT, 'h800000,  'h7FFFFF,  'h80, 1, 0,    0,         0, STATUS_OK);
      add_row(NO_WRITE, OP_LOOKUP, 'h7FFFFF,  'h800000,  0,    0, 0,    0,         0, STATUS_OK);
      add_row(0,        OP_LOOKUP, 'h123456,  'hABCDEF,  'h3C, 0, 0,    0,         0, STATUS_OK);
      add_row(255,      OP_LOOKUP, 'hFFFFFE,  'hFFFFFF,  0,    0, 0,    0,         0, STATUS_OK);
      add_row(NO_WRITE, OP_INSERT, 'hAAAAAA,  'h555555,  'h01, 1, 0,    0,         0, STATUS_OK);
      add_row(NO_WRITE, OP_LOOKUP, 'h555555,  'hAAAAAA,  0,    0, 0,    0,         0, STATUS_OK);
      add_row(128,      OP_LOOKUP, 'hAAAAAA,  'h555555,  0,    0, 0,    0,         0, STATUS_OK);

      fc_plan = '{256, 0, 1, 255, 0, 128};
      fc_plan[4] = $urandom_range(0, 256);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[n]) begin
         if (dir_rows[n].fc != NO_WRITE) write_fcount(dir_rows[n].fc);
         want = nearest_response(dir_rows[n].item);
         if (dir_rows[n].typed) want = dir_rows[n].want;
         offer(dir_rows[n].item, want);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         write_fcount(fc_plan[ph]);
         if (ph < 2) begin
            send_idle_pct = 16;
            rcv_stall_pct = 70;
         end else if (ph < 4) begin
            send_idle_pct = 70;
            rcv_stall_pct = 16;
         end else begin
            send_idle_pct = 0;
            rcv_stall_pct = 0;
         end
         if (ph == 1) hold_ask <= hold_ask + 1;
         repeat (ITEMS_PER_PHASE) begin
            r = pick_req();
            offer(r, nearest_response(r));
         end
      end

      req_valid <= 1'b0;
      while (rsp_backlog.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("l1_nearest_entry_table_tb: PASS");
      end else begin
         $display("l1_nearest_entry_table_tb: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/l1net_pkg.sv
hw/rtl/l1net_ram.sv
hw/rtl/l1net_dist.sv
hw/rtl/l1_nearest_entry_table.sv
tb/sv/l1_nearest_entry_table_tb.sv
